// ===== rtl/core/quaternion_alu_defines.svh =====
// Assertion helpers for the quaternion ALU.
`ifndef QUATERNION_ALU_DEFINES_SVH
`define QUATERNION_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define QALU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define QALU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define QALU_ASSERT_IMPL(lbl, ante, cons)
`define QALU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/qalu_pkg.sv =====
package qalu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned LEN_W = 33;
  localparam int unsigned SUMSQ_W = 64;

  typedef enum logic [2:0] {
    KIND_MUL    = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_SCALE  = 3'd2,
    KIND_CONJ   = 3'd3,
    KIND_LENGTH = 3'd4,
    KIND_NORM   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] factor;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               zero_length;
  } out_req_t;

  typedef logic [3:0][31:0] quad_t;

  // Side data that rides along with each request through the pipe.
  typedef struct packed {
    logic [2:0] kind;
    logic       zero;
    quad_t      res;
    quad_t      comp;
  } meta_t;

  function automatic logic [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) begin
      return 32'h7fff_ffff;
    end
    if (v < -67'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/qalu_prod.sv =====
module qalu_prod #(
  parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  qalu_pkg::in_req_t                in_req,
  output logic                             out_valid,
  output qalu_pkg::meta_t                  out_meta,
  output logic [qalu_pkg::SUMSQ_W-1:0]     out_sumsq
);
  import qalu_pkg::*;

  localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

  // Lane r*4+l feeds row r of the Hamilton product.
  localparam logic [1:0] MUL_A [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                        2'd0, 2'd1, 2'd2, 2'd3,
                                        2'd0, 2'd2, 2'd3, 2'd1,
                                        2'd0, 2'd3, 2'd1, 2'd2};
  localparam logic [1:0] MUL_B [16] = '{2'd0, 2'd1, 2'd2, 2'd3,
                                        2'd1, 2'd0, 2'd3, 2'd2,
                                        2'd2, 2'd0, 2'd1, 2'd3,
                                        2'd3, 2'd0, 2'd2, 2'd1};
  localparam logic       MUL_NEG [16] = '{1'b0, 1'b1, 1'b1, 1'b1,
                                         1'b0, 1'b0, 1'b0, 1'b1,
                                         1'b0, 1'b0, 1'b0, 1'b1,
                                         1'b0, 1'b0, 1'b0, 1'b1};

  logic signed [31:0] av [4];
  logic signed [31:0] bv [4];

  logic [31:0] opa_nxt [16];
  logic [31:0] opb_nxt [16];
  logic        neg_nxt [16];
  quad_t       res_nxt;

  logic [31:0] opa_r [16];
  logic [31:0] opb_r [16];
  logic        neg1_r [16];
  meta_t       meta1_r;
  logic        v1_r;

  logic signed [63:0] prod_r [16];
  logic               neg2_r [16];
  meta_t              meta2_r;
  logic               v2_r;

  logic signed [65:0] pair_nxt [4][2];
  logic signed [65:0] pair_r [4][2];
  meta_t              meta3_r;
  logic               v3_r;

  meta_t              meta4_nxt;
  logic [SUMSQ_W-1:0] sumsq_nxt;
  meta_t              meta4_r;
  logic [SUMSQ_W-1:0] sumsq_r;
  logic               v4_r;

  assign av[0] = in_req.a_w;
  assign av[1] = in_req.a_x;
  assign av[2] = in_req.a_y;
  assign av[3] = in_req.a_z;
  assign bv[0] = in_req.b_w;
  assign bv[1] = in_req.b_x;
  assign bv[2] = in_req.b_y;
  assign bv[3] = in_req.b_z;

  // Route operands to the multiplier lanes; form add and conjugate here.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      opa_nxt[i] = '0;
      opb_nxt[i] = '0;
      neg_nxt[i] = 1'b0;
    end
    res_nxt = '0;
    case (in_req.kind)
      KIND_MUL: begin
        for (int i = 0; i < 16; i++) begin
          opa_nxt[i] = av[MUL_A[i]];
          opb_nxt[i] = bv[MUL_B[i]];
          neg_nxt[i] = MUL_NEG[i];
        end
      end
      KIND_ADD: begin
        for (int r = 0; r < 4; r++) begin
          res_nxt[r] = sat32(67'(33'(av[r]) + 33'(bv[r])));
        end
      end
      KIND_SCALE: begin
        for (int r = 0; r < 4; r++) begin
          opa_nxt[r*4] = av[r];
          opb_nxt[r*4] = in_req.factor;
        end
      end
      KIND_CONJ: begin
        res_nxt[0] = av[0];
        for (int r = 1; r < 4; r++) begin
          res_nxt[r] = sat32(67'(-33'(av[r])));
        end
      end
      KIND_LENGTH, KIND_NORM: begin
        for (int l = 0; l < 4; l++) begin
          opa_nxt[l] = av[l];
          opb_nxt[l] = av[l];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        pair_nxt[r][h] =
          (neg2_r[r*4+h*2]   ? -66'(prod_r[r*4+h*2])   : 66'(prod_r[r*4+h*2])) +
          (neg2_r[r*4+h*2+1] ? -66'(prod_r[r*4+h*2+1]) : 66'(prod_r[r*4+h*2+1]));
      end
    end
  end

  // Final add, round half up, saturate; row w also yields the sum of squares.
  always_comb begin
    logic signed [66:0] s;
    logic signed [66:0] rnd;
    meta4_nxt = meta3_r;
    sumsq_nxt = '0;
    for (int r = 0; r < 4; r++) begin
      s   = 67'(pair_r[r][0]) + 67'(pair_r[r][1]);
      rnd = (s + HALF) >>> FRAC_BITS;
      if (meta3_r.kind == KIND_MUL || meta3_r.kind == KIND_SCALE) begin
        meta4_nxt.res[r] = sat32(rnd);
      end
      if (r == 0) begin
        sumsq_nxt      = (s[66:64] != 3'd0) ? '1 : s[63:0];
        meta4_nxt.zero = (s == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 16; i++) begin
        opa_r[i]  <= opa_nxt[i];
        opb_r[i]  <= opb_nxt[i];
        neg1_r[i] <= neg_nxt[i];
        prod_r[i] <= $signed(opa_r[i]) * $signed(opb_r[i]);
        neg2_r[i] <= neg1_r[i];
      end
      meta1_r.kind <= in_req.kind;
      meta1_r.zero <= 1'b0;
      meta1_r.res  <= res_nxt;
      meta1_r.comp <= {in_req.a_z, in_req.a_y, in_req.a_x, in_req.a_w};
      meta2_r      <= meta1_r;
      pair_r       <= pair_nxt;
      meta3_r      <= meta2_r;
      meta4_r      <= meta4_nxt;
      sumsq_r      <= sumsq_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_meta  = meta4_r;
  assign out_sumsq = sumsq_r;

endmodule

// ===== rtl/core/qalu_sqrt.sv =====
module qalu_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  qalu_pkg::meta_t               in_meta,
  input  logic [qalu_pkg::SUMSQ_W-1:0]  in_sumsq,
  output logic                          out_valid,
  output qalu_pkg::meta_t               out_meta,
  output logic [qalu_pkg::LEN_W-1:0]    out_len
);
  import qalu_pkg::*;

  localparam int unsigned STEPS = SUMSQ_W / 2;

  logic [STEPS-1:0]   root_i [STEPS];
  logic [STEPS+1:0]   rem_i  [STEPS];
  logic [SUMSQ_W-1:0] src_i  [STEPS];
  meta_t              meta_i [STEPS];
  logic               v_i    [STEPS];

  logic [STEPS-1:0]   root_nxt [STEPS];
  logic [STEPS+1:0]   rem_nxt  [STEPS];

  logic [STEPS-1:0]   root_r [STEPS];
  logic [STEPS+1:0]   rem_r  [STEPS];
  logic [SUMSQ_W-1:0] src_r  [STEPS];
  meta_t              meta_r [STEPS];
  logic               v_r    [STEPS];

  logic [LEN_W-1:0]   len_nxt;
  logic [LEN_W-1:0]   len_r;
  meta_t              metal_r;
  logic               vl_r;

  always_comb begin
    root_i[0] = '0;
    rem_i[0]  = '0;
    src_i[0]  = in_sumsq;
    meta_i[0] = in_meta;
    v_i[0]    = in_valid;
    for (int k = 1; k < STEPS; k++) begin
      root_i[k] = root_r[k-1];
      rem_i[k]  = rem_r[k-1];
      src_i[k]  = src_r[k-1];
      meta_i[k] = meta_r[k-1];
      v_i[k]    = v_r[k-1];
    end
  end

  // One root bit per stage: bring down two bits, try to subtract 4*root+1.
  always_comb begin
    logic [STEPS+3:0] rem_sh;
    logic [STEPS+3:0] trial;
    for (int k = 0; k < STEPS; k++) begin
      rem_sh = {rem_i[k], src_i[k][SUMSQ_W-1 -: 2]};
      trial  = {2'b00, root_i[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[k]  = (STEPS+2)'(rem_sh - trial);
        root_nxt[k] = {root_i[k][STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh[STEPS+1:0];
        root_nxt[k] = {root_i[k][STEPS-2:0], 1'b0};
      end
    end
  end

  // Round to nearest: the remainder exceeds the root exactly when it should.
  assign len_nxt = LEN_W'(root_r[STEPS-1]) +
                   LEN_W'(rem_r[STEPS-1] > (STEPS+2)'(root_r[STEPS-1]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= 1'b0;
      end
      vl_r <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= v_i[k];
      end
      vl_r <= v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        root_r[k] <= root_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        src_r[k]  <= {src_i[k][SUMSQ_W-3:0], 2'b00};
        meta_r[k] <= meta_i[k];
      end
      len_r   <= len_nxt;
      metal_r <= meta_r[STEPS-1];
    end
  end

  assign out_valid = vl_r;
  assign out_meta  = metal_r;
  assign out_len   = len_r;

endmodule

// ===== rtl/core/qalu_div.sv =====
module qalu_div #(
  parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  qalu_pkg::meta_t             in_meta,
  input  logic [qalu_pkg::LEN_W-1:0]  in_len,
  output logic                        out_valid,
  output qalu_pkg::meta_t             out_meta,
  output logic [qalu_pkg::LEN_W-1:0]  out_len,
  output logic [FRAC_BITS+32:0]       out_quot [4]
);
  import qalu_pkg::*;

  localparam int unsigned NW    = FRAC_BITS + 33;
  localparam int unsigned STEPS = NW;

  logic [NW-1:0]    num_nxt [4];
  logic [NW-1:0]    num0_r  [4];
  logic [LEN_W-1:0] den0_r;
  meta_t            meta0_r;
  logic             v0_r;

  logic [NW-1:0]    nq_i   [STEPS][4];
  logic [LEN_W-1:0] rem_i  [STEPS][4];
  logic [LEN_W-1:0] den_i  [STEPS];
  meta_t            meta_i [STEPS];
  logic             v_i    [STEPS];

  logic [NW-1:0]    nq_nxt  [STEPS][4];
  logic [LEN_W-1:0] rem_nxt [STEPS][4];

  logic [NW-1:0]    nq_r   [STEPS][4];
  logic [LEN_W-1:0] rem_r  [STEPS][4];
  logic [LEN_W-1:0] den_r  [STEPS];
  meta_t            meta_r [STEPS];
  logic             v_r    [STEPS];

  // Dividend: |c| scaled up, plus half the divisor for round to nearest.
  always_comb begin
    logic [31:0] mag;
    for (int l = 0; l < 4; l++) begin
      mag = in_meta.comp[l][31] ? 32'(-$signed(in_meta.comp[l])) : in_meta.comp[l];
      num_nxt[l] = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(in_len[LEN_W-1:1]);
    end
  end

  always_comb begin
    nq_i[0]   = num0_r;
    den_i[0]  = den0_r;
    meta_i[0] = meta0_r;
    v_i[0]    = v0_r;
    for (int l = 0; l < 4; l++) begin
      rem_i[0][l] = '0;
    end
    for (int k = 1; k < STEPS; k++) begin
      nq_i[k]   = nq_r[k-1];
      rem_i[k]  = rem_r[k-1];
      den_i[k]  = den_r[k-1];
      meta_i[k] = meta_r[k-1];
      v_i[k]    = v_r[k-1];
    end
  end

  // Restoring division, one quotient bit per stage; quotient shifts in low.
  always_comb begin
    logic [LEN_W:0] rem_sh;
    for (int k = 0; k < STEPS; k++) begin
      for (int l = 0; l < 4; l++) begin
        rem_sh = {rem_i[k][l], nq_i[k][l][NW-1]};
        if (rem_sh >= {1'b0, den_i[k]}) begin
          rem_nxt[k][l] = LEN_W'(rem_sh - {1'b0, den_i[k]});
          nq_nxt[k][l]  = {nq_i[k][l][NW-2:0], 1'b1};
        end else begin
          rem_nxt[k][l] = rem_sh[LEN_W-1:0];
          nq_nxt[k][l]  = {nq_i[k][l][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r <= in_valid;
      for (int k = 0; k < STEPS; k++) begin
        v_r[k] <= v_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r  <= num_nxt;
      den0_r  <= in_len;
      meta0_r <= in_meta;
      for (int k = 0; k < STEPS; k++) begin
        nq_r[k]   <= nq_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_i[k];
        meta_r[k] <= meta_i[k];
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_meta  = meta_r[STEPS-1];
  assign out_len   = den_r[STEPS-1];
  assign out_quot  = nq_r[STEPS-1];

endmodule

// ===== rtl/core/quaternion_alu.sv =====
// Quaternion ALU on signed fixed-point components (Q16.16 by default,
// FRAC_BITS fraction bits). Each request carries a kind, operands a and b
// and a scale factor, and yields exactly one result: Hamilton product a*b,
// sum a+b, a scaled by factor, conjugate of a, length of a (in r_w, other
// components zero) or a normalized to unit length. Every component
// saturates to the signed 32-bit range; products round to nearest with
// ties upward. Normalizing a zero quaternion returns zeros with
// zero_length set; unused kinds return all zeros. The block takes one
// request per clock while in_ready is high and returns results in order.
// The pipe is 72+FRAC_BITS register stages deep (88 at the default):
// four of operand routing, 32x32 multiply and summing, 33 of the square
// root (one root bit per stage plus rounding), 34+FRAC_BITS of the
// four-lane divider (one quotient bit per stage plus setup), and the
// output register. A two-entry output buffer lets a request in while a
// result waits to be taken; the whole pipe holds only once both entries
// are full.
`include "quaternion_alu_defines.svh"

module quaternion_alu #(
  parameter int unsigned FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qalu_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output qalu_pkg::out_req_t out_req
);
  import qalu_pkg::*;

  localparam int unsigned NW = FRAC_BITS + 33;

  logic               en;

  logic               prod_valid;
  meta_t              prod_meta;
  logic [SUMSQ_W-1:0] prod_sumsq;

  logic               sqrt_valid;
  meta_t              sqrt_meta;
  logic [LEN_W-1:0]   sqrt_len;

  logic               div_valid;
  meta_t              div_meta;
  logic [LEN_W-1:0]   div_len;
  logic [NW-1:0]      div_quot [4];

  out_req_t           fin_nxt;

  out_req_t           out_r;
  logic               out_v_r;
  out_req_t           skid_r;
  logic               skid_v_r;

  // Advance the whole pipe unless the output buffer is full.
  assign en       = !skid_v_r;
  assign in_ready = en;

  qalu_prod #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .out_valid (prod_valid),
    .out_meta  (prod_meta),
    .out_sumsq (prod_sumsq)
  );

  qalu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (prod_valid),
    .in_meta   (prod_meta),
    .in_sumsq  (prod_sumsq),
    .out_valid (sqrt_valid),
    .out_meta  (sqrt_meta),
    .out_len   (sqrt_len)
  );

  qalu_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sqrt_valid),
    .in_meta   (sqrt_meta),
    .in_len    (sqrt_len),
    .out_valid (div_valid),
    .out_meta  (div_meta),
    .out_len   (div_len),
    .out_quot  (div_quot)
  );

  // Pick the result by kind: length and normalize come out of the long
  // tail, everything else was settled in the multiply stages.
  always_comb begin
    quad_t r;
    r = div_meta.res;
    fin_nxt.zero_length = 1'b0;
    case (div_meta.kind)
      KIND_LENGTH: begin
        r    = '0;
        r[0] = (div_len > LEN_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : div_len[31:0];
      end
      KIND_NORM: begin
        r = '0;
        if (div_meta.zero) begin
          fin_nxt.zero_length = 1'b1;
        end else begin
          for (int l = 0; l < 4; l++) begin
            if (div_meta.comp[l][31]) begin
              r[l] = (div_quot[l] > NW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                          : 32'(-div_quot[l][31:0]);
            end else begin
              r[l] = (div_quot[l] > NW'(32'h7fff_ffff)) ? 32'h7fff_ffff
                                                        : div_quot[l][31:0];
            end
          end
        end
      end
      default: ;
    endcase
    fin_nxt.r_w = r[0];
    fin_nxt.r_x = r[1];
    fin_nxt.r_y = r[2];
    fin_nxt.r_z = r[3];
  end

  // Output register plus skid entry: drop a finished request into the
  // skid slot while the output is stalled, drain it first once it moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_ready) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= div_valid && en;
        end
      end else if (div_valid && en) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : fin_nxt;
    end else if (div_valid && en) begin
      skid_r <= fin_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_req   = out_r;

  `QALU_ASSERT_IMPL(a_skid_behind_out, skid_v_r, out_v_r)
  `QALU_ASSERT_NEXT(a_skid_catches, out_v_r && !out_ready && !skid_v_r && div_valid, skid_v_r)
  `QALU_ASSERT_IMPL(a_flag_zero_result, out_v_r && out_r.zero_length, out_r.r_w == '0 && out_r.r_x == '0 && out_r.r_y == '0 && out_r.r_z == '0)

endmodule
